@@ rtl/cave_automaton_smoother_assert.svh @@
// Assertion macros for the cave smoothing block.
// Included by the top level; the macros expect signals clk and rst_n in scope.
`ifndef CAVE_AUTOMATON_SMOOTHER_ASSERT_SVH
`define CAVE_AUTOMATON_SMOOTHER_ASSERT_SVH
`ifndef SYNTHESIS
`define CAS_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cave smoother: same-cycle check failed");
`define CAS_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("cave smoother: next-cycle check failed");
`else
`define CAS_ASSERT_IMP(name, cond, prop)
`define CAS_ASSERT_NEXT(name, cond, prop)
`endif
`endif

@@ rtl/cas_pkg.sv @@
// Shared constants and types of the cave smoothing block.
// No dependencies; used by the interfaces, the cell, the rule unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

    localparam int CAS_ROW_BITS = 64;
    localparam int CAS_MAX_ROWS = 64;
    localparam int CAS_IDX_W    = 6;
    localparam int CAS_DIM_W    = 7;
    localparam int CAS_CNT4_W   = 4;
    localparam int CAS_ADDR_W   = 4;
    localparam int CAS_DATA_W   = 32;

    localparam logic [CAS_DIM_W-1:0]  CAS_MIN_DIM        = 7'd3;
    localparam logic [CAS_DIM_W-1:0]  CAS_RST_WIDTH      = 7'd64;
    localparam logic [CAS_DIM_W-1:0]  CAS_RST_HEIGHT     = 7'd36;
    localparam logic [CAS_CNT4_W-1:0] CAS_RST_PASSES     = 4'd5;
    localparam logic [CAS_CNT4_W-1:0] CAS_RST_THRESHOLD  = 4'd5;

    localparam logic [1:0] REG_MAP_WIDTH      = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_PASS_COUNT     = 2'd2;
    localparam logic [1:0] REG_WALL_THRESHOLD = 2'd3;

    typedef struct packed {
        logic                 load;
        logic                 shift;
        logic [CAS_IDX_W-1:0] load_idx;
        logic [CAS_IDX_W-1:0] tail_idx;
    } cas_cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/cas_ifs.sv @@
// Valid/ready channel interfaces for input rows and smoothed output rows.
// Depends on cas_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cas_row_if
    import cas_pkg::*;
#(
    parameter int ROW_BITS = CAS_ROW_BITS
);
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] row_bits;

    modport source (output valid, output row_bits, input ready);
    modport sink   (input valid, input row_bits, output ready);
endinterface

interface cas_out_if
    import cas_pkg::*;
#(
    parameter int ROW_BITS = CAS_ROW_BITS
);
    logic                 valid;
    logic                 ready;
    logic [ROW_BITS-1:0]  out_row_bits;
    logic [CAS_IDX_W-1:0] row_index;
    logic                 last_row;

    modport source (output valid, output out_row_bits, output row_index, output last_row,
                    input ready);
    modport sink   (input valid, input out_row_bits, input row_index, input last_row,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/cas_cell.sv @@
// One row cell of the grid chain: holds a row, loads it by index or shifts from its neighbor.
// Depends on cas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cas_cell
    import cas_pkg::*;
#(
    parameter int ROW_BITS = CAS_ROW_BITS,
    parameter int INDEX    = 0
)
(
    input  wire logic                clk,
    input  wire cas_cell_ctl_t       ctl,
    input  wire logic [ROW_BITS-1:0] insert_row,
    input  wire logic [ROW_BITS-1:0] neighbor_row,
    output logic      [ROW_BITS-1:0] row
);

    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    logic                hit_load;
    logic                hit_tail;

    assign hit_load = (ctl.load_idx == CAS_IDX_W'(INDEX));
    assign hit_tail = (ctl.tail_idx == CAS_IDX_W'(INDEX));

    always_comb
    begin
        row_next = row_reg;
        if (ctl.load && hit_load)
        begin
            row_next = insert_row;
        end
        else if (ctl.shift)
        begin
            row_next = hit_tail ? insert_row : neighbor_row;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign row = row_reg;

endmodule

`default_nettype wire

@@ rtl/cas_rule.sv @@
// Smoothing rule for one row: counts the eight neighbors of every interior column against the threshold.
// Depends on cas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cas_rule
    import cas_pkg::*;
#(
    parameter int ROW_BITS = CAS_ROW_BITS
)
(
    input  wire logic [ROW_BITS-1:0]   above,
    input  wire logic [ROW_BITS-1:0]   mid,
    input  wire logic [ROW_BITS-1:0]   below,
    input  wire logic [ROW_BITS-1:0]   mask,
    input  wire logic [CAS_DIM_W-1:0]  width,
    input  wire logic [CAS_CNT4_W-1:0] threshold,
    input  wire logic                  border_row,
    output logic      [ROW_BITS-1:0]   new_row
);

    genvar x;
    generate
        for (x = 0; x < ROW_BITS; x++)
        begin : g_col
            logic                  l_a;
            logic                  l_m;
            logic                  l_b;
            logic                  r_a;
            logic                  r_m;
            logic                  r_b;
            logic [CAS_CNT4_W-1:0] walls;
            logic                  border_col;
            logic                  interior;

            if (x == 0)
            begin : g_left_edge
                assign l_a = 1'b0;
                assign l_m = 1'b0;
                assign l_b = 1'b0;
            end
            else
            begin : g_left
                assign l_a = above[x-1];
                assign l_m = mid[x-1];
                assign l_b = below[x-1];
            end

            if (x == ROW_BITS - 1)
            begin : g_right_edge
                assign r_a = 1'b0;
                assign r_m = 1'b0;
                assign r_b = 1'b0;
            end
            else
            begin : g_right
                assign r_a = above[x+1];
                assign r_m = mid[x+1];
                assign r_b = below[x+1];
            end

            assign walls = CAS_CNT4_W'(l_a) + CAS_CNT4_W'(above[x]) + CAS_CNT4_W'(r_a)
                         + CAS_CNT4_W'(l_m) + CAS_CNT4_W'(r_m)
                         + CAS_CNT4_W'(l_b) + CAS_CNT4_W'(below[x]) + CAS_CNT4_W'(r_b);

            assign border_col = (x == 0) || (CAS_DIM_W'(x) == width - CAS_DIM_W'(1));
            assign interior   = (x != 0) && ((CAS_DIM_W'(x) + CAS_DIM_W'(1)) < width);

            assign new_row[x] = border_row ? mask[x]
                              : (mask[x] & (border_col | (interior & (walls >= threshold))));
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/cave_automaton_smoother.sv @@
// Cave smoothing block: stores a grid row by row, runs the threshold rule passes and streams the rows.
// A grid of h rows is loaded row by row, then passed pass_count times (one row per cycle through the
// rule unit at the head of the row chain), then streamed out as h rows, held back while the sink stalls.
// Reset (rst_n, asynchronous, active low) restores the register defaults and empties the grid
// count; grid rows are not cleared and are always written before they are read.
`timescale 1ns / 1ps
`default_nettype none

module cave_automaton_smoother
    import cas_pkg::*;
#(
    parameter int ROW_BITS = CAS_ROW_BITS,
    parameter int MAX_ROWS = CAS_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cas_row_if.sink                    in_ch,
    cas_out_if.source                  out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CAS_ADDR_W-1:0] paddr,
    input  wire logic [CAS_DATA_W-1:0] pwdata,
    output logic      [CAS_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS);

    typedef enum logic [1:0] {
        S_LOAD,
        S_PASS,
        S_EMIT
    } state_t;

    logic [CAS_DIM_W-1:0]  map_width_reg;
    logic [CAS_DIM_W-1:0]  map_height_reg;
    logic [CAS_CNT4_W-1:0] pass_count_reg;
    logic [CAS_CNT4_W-1:0] wall_threshold_reg;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [CAS_CNT4_W-1:0] pass_reg;
    logic [CAS_CNT4_W-1:0] pass_next;
    logic [ROW_BITS-1:0]   prev_reg;
    logic [ROW_BITS-1:0]   prev_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROW_BITS-1:0]   out_row_reg;
    logic [ROW_BITS-1:0]   out_row_next;
    logic [CAS_IDX_W-1:0]  out_idx_reg;
    logic [CAS_IDX_W-1:0]  out_idx_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic [CAS_DIM_W-1:0]  eff_w;
    logic [CAS_DIM_W-1:0]  eff_h;
    logic [CAS_DIM_W-1:0]  last_idx;
    logic [ROW_BITS-1:0]   mask;
    logic [ROW_BITS-1:0]   cell_q [MAX_ROWS];
    logic [ROW_BITS-1:0]   insert_row;
    logic [ROW_BITS-1:0]   new_row;
    cas_cell_ctl_t         ctl;
    logic                  in_fire;
    logic                  emit_fire;
    logic                  row_is_last;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg      <= CAS_RST_WIDTH;
            map_height_reg     <= CAS_RST_HEIGHT;
            pass_count_reg     <= CAS_RST_PASSES;
            wall_threshold_reg <= CAS_RST_THRESHOLD;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MAP_WIDTH:      map_width_reg      <= pwdata[CAS_DIM_W-1:0];
                REG_MAP_HEIGHT:     map_height_reg     <= pwdata[CAS_DIM_W-1:0];
                REG_PASS_COUNT:     pass_count_reg     <= pwdata[CAS_CNT4_W-1:0];
                REG_WALL_THRESHOLD: wall_threshold_reg <= pwdata[CAS_CNT4_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAP_WIDTH:      prdata = CAS_DATA_W'(map_width_reg);
            REG_MAP_HEIGHT:     prdata = CAS_DATA_W'(map_height_reg);
            REG_PASS_COUNT:     prdata = CAS_DATA_W'(pass_count_reg);
            REG_WALL_THRESHOLD: prdata = CAS_DATA_W'(wall_threshold_reg);
            default:            prdata = '0;
        endcase
    end

    // Effective dimensions and column mask.
    always_comb
    begin
        eff_w = map_width_reg;
        if (eff_w < CAS_MIN_DIM)
        begin
            eff_w = CAS_MIN_DIM;
        end
        if (eff_w > CAS_DIM_W'(ROW_BITS))
        begin
            eff_w = CAS_DIM_W'(ROW_BITS);
        end
        eff_h = map_height_reg;
        if (eff_h < CAS_MIN_DIM)
        begin
            eff_h = CAS_MIN_DIM;
        end
        if (eff_h > CAS_DIM_W'(MAX_ROWS))
        begin
            eff_h = CAS_DIM_W'(MAX_ROWS);
        end
    end

    assign last_idx = eff_h - CAS_DIM_W'(1);

    genvar gx;
    generate
        for (gx = 0; gx < ROW_BITS; gx++)
        begin : g_mask
            assign mask[gx] = (CAS_DIM_W'(gx) < eff_w);
        end
    endgenerate

    // Row chain: cell 0 is the head, each cell below the tail takes its upper neighbor on a shift.
    assign ctl.load     = in_fire;
    assign ctl.shift    = (state_reg == S_PASS) || emit_fire;
    assign ctl.load_idx = CAS_IDX_W'(cnt_reg);
    assign ctl.tail_idx = CAS_IDX_W'(last_idx);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ROWS; gi++)
        begin : g_cell
            logic [ROW_BITS-1:0] nb_row;
            if (gi == MAX_ROWS - 1)
            begin : g_top
                assign nb_row = insert_row;
            end
            else
            begin : g_inner
                assign nb_row = cell_q[gi+1];
            end

            cas_cell #(
                .ROW_BITS (ROW_BITS),
                .INDEX    (gi)
            ) u_cell (
                .clk          (clk),
                .ctl          (ctl),
                .insert_row   (insert_row),
                .neighbor_row (nb_row),
                .row          (cell_q[gi])
            );
        end
    endgenerate

    assign row_is_last = (CAS_DIM_W'(row_reg) == last_idx);

    cas_rule #(
        .ROW_BITS (ROW_BITS)
    ) u_rule (
        .above      (prev_reg),
        .mid        (cell_q[0]),
        .below      (cell_q[1]),
        .mask       (mask),
        .width      (eff_w),
        .threshold  (wall_threshold_reg),
        .border_row ((row_reg == '0) || row_is_last),
        .new_row    (new_row)
    );

    always_comb
    begin
        case (state_reg)
            S_LOAD:  insert_row = in_ch.row_bits & mask;
            S_PASS:  insert_row = new_row;
            default: insert_row = cell_q[0];
        endcase
    end

    // Sequencer.
    assign in_ch.ready = (state_reg == S_LOAD);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign emit_fire   = (state_reg == S_EMIT) && (!out_valid_reg || out_ch.ready);
    assign cnt_inc     = cnt_reg + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        pass_next      = pass_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    cnt_next = cnt_inc;
                    if (CAS_DIM_W'(cnt_inc) >= eff_h)
                    begin
                        cnt_next  = '0;
                        row_next  = '0;
                        pass_next = '0;
                        state_next = (pass_count_reg == '0) ? S_EMIT : S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                prev_next = cell_q[0];
                row_next  = row_reg + ROW_W'(1);
                if (row_is_last)
                begin
                    row_next  = '0;
                    pass_next = pass_reg + CAS_CNT4_W'(1);
                    if (pass_reg == pass_count_reg - CAS_CNT4_W'(1))
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = cell_q[0] & mask;
                    out_idx_next   = CAS_IDX_W'(row_reg);
                    out_last_next  = row_is_last;
                    row_next       = row_reg + ROW_W'(1);
                    if (row_is_last)
                    begin
                        row_next   = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            row_reg       <= '0;
            pass_reg      <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            pass_reg      <= pass_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            out_row_reg   <= out_row_next;
            out_idx_reg   <= out_idx_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_row_bits = out_row_reg;
    assign out_ch.row_index    = out_idx_reg;
    assign out_ch.last_row     = out_last_reg;

`include "cave_automaton_smoother_assert.svh"

    `CAS_ASSERT_IMP(a_count_idle_outside_load, state_reg != S_LOAD, cnt_reg == '0)
    `CAS_ASSERT_IMP(a_pass_row_in_grid, state_reg != S_LOAD, CAS_DIM_W'(row_reg) < eff_h)
    `CAS_ASSERT_IMP(a_last_row_index, out_valid_reg && out_last_reg, out_idx_reg == ctl.tail_idx)
    `CAS_ASSERT_NEXT(a_emit_last_returns, emit_fire && row_is_last, in_ch.ready && out_valid_reg)

endmodule

`default_nettype wire
